### rtl/cce_pkg.sv
package cce_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_QUOTED = 2'd1,
        MODE_QSEEN  = 2'd2
    } parse_mode_t;

    // Which result the output register takes in a cycle.
    typedef enum logic [1:0] {
        OUT_NONE  = 2'd0,
        OUT_SPACE = 2'd1,
        OUT_CHAR  = 2'd2,
        OUT_MARK  = 2'd3
    } out_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FLUSH = 2'd1,
        ST_CHAR  = 2'd2,
        ST_TAIL  = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic     accept;
        out_sel_t sel;
        logic     run_last;
    } cce_cmd_t;

    typedef struct packed {
        logic out_free;
        logic flush_any;
        logic flush_last;
        logic char_emit;
        logic end_emit;
        logic eot_emit;
    } cce_status_t;

endpackage

### rtl/cce_ctrl.sv
module cce_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  cce_pkg::cce_status_t st,
    output cce_pkg::cce_cmd_t    cmd
);

    cce_pkg::ctrl_state_t state_reg, state_next;
    logic                 eot_reg, eot_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cce_pkg::ST_IDLE;
            eot_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            eot_reg   <= eot_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        eot_next     = eot_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.sel      = cce_pkg::OUT_NONE;
        cmd.run_last = 1'b0;
        case (state_reg)
            cce_pkg::ST_IDLE: begin
                s_tready = st.out_free;
                if (s_tvalid && st.out_free) begin
                    cmd.accept = 1'b1;
                    eot_next   = st.eot_emit;
                    if (st.flush_any) begin
                        state_next = cce_pkg::ST_FLUSH;
                    end else if (st.char_emit || st.end_emit) begin
                        // The first result is loaded into the output register in the same cycle as the transfer.
                        cmd.sel      = st.char_emit ? cce_pkg::OUT_CHAR : cce_pkg::OUT_MARK;
                        cmd.run_last = !st.eot_emit;
                        if (st.eot_emit) begin
                            state_next = cce_pkg::ST_TAIL;
                        end
                    end else if (st.eot_emit) begin
                        cmd.sel      = cce_pkg::OUT_MARK;
                        cmd.run_last = 1'b1;
                    end
                end
            end
            cce_pkg::ST_FLUSH: begin
                if (st.out_free) begin
                    cmd.sel = cce_pkg::OUT_SPACE;
                    if (st.flush_last) begin
                        state_next = cce_pkg::ST_CHAR;
                    end
                end
            end
            cce_pkg::ST_CHAR: begin
                if (st.out_free) begin
                    cmd.sel      = cce_pkg::OUT_CHAR;
                    cmd.run_last = !eot_reg;
                    state_next   = eot_reg ? cce_pkg::ST_TAIL : cce_pkg::ST_IDLE;
                end
            end
            cce_pkg::ST_TAIL: begin
                if (st.out_free) begin
                    cmd.sel      = cce_pkg::OUT_MARK;
                    cmd.run_last = 1'b1;
                    state_next   = cce_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cce_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A byte that flushes whitespace always hands over to the byte itself once the flush is done.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cce_pkg::ST_FLUSH && st.out_free && st.flush_last)
            |=> (state_reg == cce_pkg::ST_CHAR))
        else $error("flush did not hand over to the data byte");

    // No new transfer is taken while results of the previous byte are owed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> (state_reg == cce_pkg::ST_IDLE))
        else $error("input taken while results were pending");

    // The end-of-text mark is the last result of its byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cce_pkg::ST_TAIL && cmd.sel != cce_pkg::OUT_NONE) |-> cmd.run_last)
        else $error("end-of-text mark not flagged as last");
`endif

endmodule

### rtl/cce_datapath.sv
module cce_datapath #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  cce_pkg::cce_cmd_t    cmd,
    output cce_pkg::cce_status_t st,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int AW = $clog2(PENDING_DEPTH);
    localparam int CW = $clog2(PENDING_DEPTH + 2);

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
    endfunction

    logic [15:0]          sel_reg;
    cce_pkg::parse_mode_t mode_reg, mode_next;
    logic [15:0]          col_reg, col_next;
    logic                 started_reg, started_next;
    logic                 nonempty_reg, nonempty_next;
    logic [CW-1:0]        pcount_reg, pcount_next;

    logic [7:0]           pend_mem [PENDING_DEPTH];
    logic [7:0]           rd_data_reg;
    logic [AW-1:0]        rd_idx_reg, rd_idx_next;
    logic [CW-1:0]        flush_cnt_reg, flush_cnt_next;
    logic [7:0]           char_reg;
    logic                 ovf_reg, ovf_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [7:0]           m_tdata_reg;
    logic [2:0]           m_tuser_reg;
    logic                 m_tlast_reg;

    logic                 hit, take, fend, normal_path, ws_wr;
    logic                 char_emit, end_emit, eot_emit;

    // Decode of the byte at the input against the parser state.
    always_comb begin
        mode_next      = mode_reg;
        col_next       = col_reg;
        started_next   = started_reg;
        nonempty_next  = nonempty_reg;
        pcount_next    = pcount_reg;
        hit            = (col_reg == sel_reg);
        take           = 1'b0;
        fend           = 1'b0;
        normal_path    = 1'b0;
        ws_wr          = 1'b0;
        char_emit      = 1'b0;
        end_emit       = 1'b0;
        ovf_next       = 1'b0;
        flush_cnt_next = (pcount_reg > CW'(PENDING_DEPTH)) ? CW'(PENDING_DEPTH) : pcount_reg;

        case (mode_reg)
            cce_pkg::MODE_QUOTED: begin
                if (s_tdata == cce_pkg::CH_QUOTE) begin
                    mode_next = cce_pkg::MODE_QSEEN;
                end else begin
                    take = 1'b1;
                end
            end
            cce_pkg::MODE_QSEEN: begin
                if (s_tdata == cce_pkg::CH_QUOTE) begin
                    take      = 1'b1;
                    mode_next = cce_pkg::MODE_QUOTED;
                end else begin
                    mode_next   = cce_pkg::MODE_NORMAL;
                    normal_path = 1'b1;
                end
            end
            default: begin
                mode_next   = cce_pkg::MODE_NORMAL;
                normal_path = 1'b1;
            end
        endcase

        if (normal_path) begin
            if (s_tdata == cce_pkg::CH_COMMA) begin
                fend     = 1'b1;
                col_next = col_reg + 16'd1;
            end else if (s_tdata == cce_pkg::CH_QUOTE) begin
                mode_next = cce_pkg::MODE_QUOTED;
            end else if (s_tdata == cce_pkg::CH_CR) begin
                fend     = 1'b1;
                col_next = 16'd0;
            end else begin
                take = 1'b1;
            end
        end

        if (take) begin
            started_next = 1'b1;
            if (is_ws(s_tdata)) begin
                // Whitespace after content may turn out to be inner text, so it waits.
                if (nonempty_reg) begin
                    ws_wr = (pcount_reg < CW'(PENDING_DEPTH));
                    if (pcount_reg <= CW'(PENDING_DEPTH)) begin
                        pcount_next = pcount_reg + CW'(1);
                    end
                end
            end else begin
                char_emit     = hit;
                ovf_next      = hit && (pcount_reg > CW'(PENDING_DEPTH));
                pcount_next   = '0;
                nonempty_next = 1'b1;
            end
        end

        if (fend) begin
            end_emit      = hit;
            started_next  = 1'b0;
            nonempty_next = 1'b0;
            pcount_next   = '0;
        end

        eot_emit = s_tlast && started_next && (col_next == sel_reg);

        if (s_tlast) begin
            mode_next     = cce_pkg::MODE_NORMAL;
            col_next      = 16'd0;
            started_next  = 1'b0;
            nonempty_next = 1'b0;
            pcount_next   = '0;
        end
    end

    assign st.out_free   = !m_tvalid_reg || m_tready;
    assign st.flush_any  = char_emit && (pcount_reg != '0);
    assign st.flush_last = ((CW'(rd_idx_reg) + CW'(1)) == flush_cnt_reg);
    assign st.char_emit  = char_emit;
    assign st.end_emit   = end_emit;
    assign st.eot_emit   = eot_emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg      <= 16'd0;
            mode_reg     <= cce_pkg::MODE_NORMAL;
            col_reg      <= 16'd0;
            started_reg  <= 1'b0;
            nonempty_reg <= 1'b0;
            pcount_reg   <= '0;
            rd_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                sel_reg <= cfg_wr_data;
            end
            if (cmd.accept) begin
                mode_reg     <= mode_next;
                col_reg      <= col_next;
                started_reg  <= started_next;
                nonempty_reg <= nonempty_next;
                pcount_reg   <= pcount_next;
            end
            rd_idx_reg   <= rd_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // The read address runs one step ahead so that the registered read data
    // always belongs to the entry that is due next.
    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.accept) begin
            rd_idx_next = '0;
        end else if (cmd.sel == cce_pkg::OUT_SPACE) begin
            rd_idx_next = st.flush_last ? '0 : rd_idx_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && ws_wr) begin
            pend_mem[pcount_reg[AW-1:0]] <= s_tdata;
        end
        rd_data_reg <= pend_mem[rd_idx_next];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            char_reg      <= s_tdata;
            ovf_reg       <= ovf_next;
            flush_cnt_reg <= flush_cnt_next;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (cmd.sel != cce_pkg::OUT_NONE) begin
            m_tvalid_next = 1'b1;
        end
    end

    // Output register. tuser bit 0 is byte_valid, bit 1 field_end, bit 2 space_overflow.
    always_ff @(posedge aclk) begin
        if (cmd.sel != cce_pkg::OUT_NONE) begin
            m_tlast_reg    <= cmd.run_last;
            m_tuser_reg[2] <= cmd.accept ? 1'b0 : ovf_reg;
            case (cmd.sel)
                cce_pkg::OUT_SPACE: begin
                    m_tdata_reg      <= rd_data_reg;
                    m_tuser_reg[1:0] <= 2'b01;
                end
                cce_pkg::OUT_CHAR: begin
                    m_tdata_reg      <= cmd.accept ? s_tdata : char_reg;
                    m_tuser_reg[1:0] <= 2'b01;
                end
                default: begin
                    m_tdata_reg      <= 8'd0;
                    m_tuser_reg[1:0] <= 2'b10;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        pcount_reg <= CW'(PENDING_DEPTH + 1))
        else $error("pending count beyond overflow value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sel == cce_pkg::OUT_SPACE) |-> (CW'(rd_idx_reg) < flush_cnt_reg))
        else $error("whitespace read beyond the flush count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sel != cce_pkg::OUT_NONE) |-> st.out_free)
        else $error("output register overwritten while held");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && s_tlast) |=> (pcount_reg == '0 && col_reg == 16'd0 && !started_reg))
        else $error("parser not cleared after end of text");
`endif

endmodule

### rtl/csv_column_extractor.sv
// The first result of a byte is loaded into the output register in the same cycle as its transfer,
// or from the FLUSH state after it when buffered whitespace has to be flushed ahead of it.
// Throughput: one byte per cycle while no buffered whitespace is flushed, no end-of-text mark
// follows another result of the same byte and the output is not held; a byte that flushes
// buffered whitespace primes the registered read port of the whitespace buffer, then sends each
// buffered byte and then the byte itself; an end-of-text mark after another result uses ST_TAIL.
// Reset (aresetn low at a clock edge) clears the parser state, column_select and the output;
// the whitespace buffer is not cleared, since only entries written since are ever read.
module csv_column_extractor #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // column_select
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // text_byte
    input  logic        s_tlast,      // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // field_byte
    output logic [2:0]  m_tuser,      // byte_valid, field_end, space_overflow
    output logic        m_tlast       // run_last
);

    cce_pkg::cce_cmd_t    cmd;
    cce_pkg::cce_status_t st;

    cce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cce_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cmd         (cmd),
        .st          (st),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
